### hw/rtl/ths_pkg.sv
// Package for the timer heap scheduler: operation, result and status codes,
// and the command and status structs between the controller and the datapath.
// Depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

package ths_pkg;

    // Fixed field widths and the limit of expiry results per tick.
    localparam int ID_W   = 5;
    localparam int DL_W   = 64;
    localparam int IVL_W  = 32;
    localparam int MAX_OUT = 32;
    localparam int N_W    = 6;

    // Operation codes of an input item.
    typedef enum logic [1:0] {
        FN_START = 2'd0,
        FN_STOP  = 2'd1,
        FN_TICK  = 2'd2,
        FN_QUERY = 2'd3
    } func_t;

    // Result kinds.
    localparam logic [1:0] KIND_REPLY  = 2'd0;
    localparam logic [1:0] KIND_EXPIRY = 2'd1;
    localparam logic [1:0] KIND_IDLE   = 2'd2;

    // Reply status codes.
    localparam logic [2:0] ST_OK         = 3'd0;
    localparam logic [2:0] ST_FULL       = 3'd1;
    localparam logic [2:0] ST_BAD_IVL    = 3'd2;
    localparam logic [2:0] ST_NOT_ACTIVE = 3'd3;
    localparam logic [2:0] ST_ALREADY    = 3'd4;

    // Datapath commands issued by the controller.
    typedef enum logic [4:0] {
        CMD_NONE,
        CMD_ACCEPT,
        CMD_DECODE,
        CMD_QRY,
        CMD_TICK,
        CMD_ARM,
        CMD_ARM_DONE,
        CMD_RISE_RD,
        CMD_RISE_MOVE,
        CMD_SINK_RD,
        CMD_SINK_LATL,
        CMD_SINK_PICK,
        CMD_SINK_MOVE,
        CMD_PLACE,
        CMD_DIS_RD,
        CMD_DIS_MV,
        CMD_DIS_LD,
        CMD_DIS_DONE,
        CMD_TOP_RD,
        CMD_POP,
        CMD_EMIT_END,
        CMD_REPLY
    } cmd_code_t;

    typedef struct packed {
        cmd_code_t code;
    } ctrl_cmd_t;

    // Status flags returned by the datapath.
    typedef struct packed {
        func_t fn;
        logic  bad_id;
        logic  reject;
        logic  rise_root;
        logic  rise_stop;
        logic  sink_leaf;
        logic  has_right;
        logic  sink_stop;
        logic  mv_none;
        logic  heap_empty;
        logic  n_full;
        logic  top_due;
        logic  pend;
        logic  periodic;
        logic  out_free;
    } dp_status_t;

endpackage

`default_nettype wire

### hw/rtl/ths_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// Depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

module ths_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  wire logic                             clk,
    input  wire logic                             we,
    input  wire logic [$clog2(DEPTH)-1:0]         waddr,
    input  wire logic [WIDTH-1:0]                 wdata,
    input  wire logic                             re,
    input  wire logic [$clog2(DEPTH)-1:0]         raddr,
    output logic      [WIDTH-1:0]                 rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];

    // Write port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
    end

    // Registered read; the data holds while no read is enabled.
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem_reg[raddr];
        end
    end

endmodule

`default_nettype wire

### hw/rtl/ths_ctrl.sv
// Controller state machine of the timer heap scheduler: sequences decode,
// sift up, sift down, disarm, re-arm and result transfers. Uses ths_pkg.
`timescale 1ns / 1ps
`default_nettype none

module ths_ctrl (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                in_valid,
    output logic                     in_ready,
    input  wire ths_pkg::dp_status_t st,
    output ths_pkg::ctrl_cmd_t       cmd
);

    import ths_pkg::*;

    typedef enum logic [19:0] {
        S_IDLE     = 20'h00001,
        S_DECODE   = 20'h00002,
        S_QRY      = 20'h00004,
        S_REPLY    = 20'h00008,
        S_ARM      = 20'h00010,
        S_ARM_DONE = 20'h00020,
        S_DIS_RD   = 20'h00040,
        S_DIS_MV   = 20'h00080,
        S_DIS_LD   = 20'h00100,
        S_DIS_DONE = 20'h00200,
        S_RISE     = 20'h00400,
        S_RISE_CMP = 20'h00800,
        S_SINK     = 20'h01000,
        S_SINK_L   = 20'h02000,
        S_SINK_R   = 20'h04000,
        S_SINK_CMP = 20'h08000,
        S_PLACE    = 20'h10000,
        S_TICK_TOP = 20'h20000,
        S_TICK_CHK = 20'h40000,
        S_TICK_END = 20'h80000
    } state_t;

    state_t state_reg, state_next;
    logic   disarm_reg, disarm_next;

    assign in_ready = (state_reg == S_IDLE);

    // Next state and command.
    always_comb
    begin
        state_next  = state_reg;
        disarm_next = disarm_reg;
        cmd.code    = CMD_NONE;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.code   = CMD_ACCEPT;
                    state_next = S_DECODE;
                end
            end
            S_DECODE:
            begin
                cmd.code = CMD_DECODE;
                if (st.fn == FN_TICK)
                begin
                    cmd.code   = CMD_TICK;
                    state_next = S_TICK_TOP;
                end
                else if (st.reject || st.bad_id)
                begin
                    state_next = S_REPLY;
                end
                else if (st.fn == FN_START)
                begin
                    state_next = S_ARM;
                end
                else if (st.fn == FN_STOP)
                begin
                    state_next = S_DIS_RD;
                end
                else
                begin
                    state_next = S_QRY;
                end
            end
            S_QRY:
            begin
                cmd.code   = CMD_QRY;
                state_next = S_REPLY;
            end
            S_REPLY:
            begin
                if (st.out_free)
                begin
                    cmd.code   = CMD_REPLY;
                    state_next = S_IDLE;
                end
            end
            S_ARM:
            begin
                cmd.code    = CMD_ARM;
                disarm_next = 1'b0;
                state_next  = S_RISE;
            end
            S_ARM_DONE:
            begin
                cmd.code   = CMD_ARM_DONE;
                state_next = (st.fn == FN_START) ? S_REPLY : S_TICK_TOP;
            end
            S_DIS_RD:
            begin
                cmd.code    = CMD_DIS_RD;
                disarm_next = 1'b1;
                state_next  = S_DIS_MV;
            end
            S_DIS_MV:
            begin
                cmd.code   = CMD_DIS_MV;
                state_next = st.mv_none ? S_DIS_DONE : S_DIS_LD;
            end
            S_DIS_LD:
            begin
                cmd.code   = CMD_DIS_LD;
                state_next = S_RISE;
            end
            S_DIS_DONE:
            begin
                cmd.code = CMD_DIS_DONE;
                if (st.fn == FN_STOP)
                begin
                    state_next = S_REPLY;
                end
                else
                begin
                    state_next = st.periodic ? S_ARM : S_TICK_TOP;
                end
            end
            S_RISE:
            begin
                if (st.rise_root)
                begin
                    state_next = disarm_reg ? S_SINK : S_PLACE;
                end
                else
                begin
                    cmd.code   = CMD_RISE_RD;
                    state_next = S_RISE_CMP;
                end
            end
            S_RISE_CMP:
            begin
                if (st.rise_stop)
                begin
                    state_next = disarm_reg ? S_SINK : S_PLACE;
                end
                else
                begin
                    cmd.code   = CMD_RISE_MOVE;
                    state_next = S_RISE;
                end
            end
            S_SINK:
            begin
                if (st.sink_leaf)
                begin
                    state_next = S_PLACE;
                end
                else
                begin
                    cmd.code   = CMD_SINK_RD;
                    state_next = S_SINK_L;
                end
            end
            S_SINK_L:
            begin
                cmd.code   = CMD_SINK_LATL;
                state_next = st.has_right ? S_SINK_R : S_SINK_CMP;
            end
            S_SINK_R:
            begin
                cmd.code   = CMD_SINK_PICK;
                state_next = S_SINK_CMP;
            end
            S_SINK_CMP:
            begin
                if (st.sink_stop)
                begin
                    state_next = S_PLACE;
                end
                else
                begin
                    cmd.code   = CMD_SINK_MOVE;
                    state_next = S_SINK;
                end
            end
            S_PLACE:
            begin
                cmd.code   = CMD_PLACE;
                state_next = disarm_reg ? S_DIS_DONE : S_ARM_DONE;
            end
            S_TICK_TOP:
            begin
                if (st.heap_empty || st.n_full)
                begin
                    state_next = S_TICK_END;
                end
                else
                begin
                    cmd.code   = CMD_TOP_RD;
                    state_next = S_TICK_CHK;
                end
            end
            S_TICK_CHK:
            begin
                if (!st.top_due)
                begin
                    state_next = S_TICK_END;
                end
                else if (!st.pend || st.out_free)
                begin
                    cmd.code   = CMD_POP;
                    state_next = S_DIS_RD;
                end
            end
            S_TICK_END:
            begin
                if (st.out_free)
                begin
                    cmd.code   = CMD_EMIT_END;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            disarm_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            disarm_reg <= disarm_next;
        end
    end

endmodule

`default_nettype wire

### hw/rtl/ths_dpath.sv
// Datapath of the timer heap scheduler: time counter, heap and timer tables
// in RAM, sift registers and the output register. Uses ths_pkg and ths_ram.
`timescale 1ns / 1ps
`default_nettype none

module ths_dpath #(
    parameter int TIMERS = 32
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire ths_pkg::ctrl_cmd_t          cmd,
    output ths_pkg::dp_status_t              st,
    input  wire logic [1:0]                  func,
    input  wire logic [ths_pkg::ID_W-1:0]    timer_id,
    input  wire logic [ths_pkg::IVL_W-1:0]   interval,
    input  wire logic                        periodic,
    output logic                             out_valid,
    input  wire logic                        out_ready,
    output logic [1:0]                       kind,
    output logic [ths_pkg::ID_W-1:0]         result_timer,
    output logic [2:0]                       status,
    output logic                             new_earliest,
    output logic [ths_pkg::IVL_W-1:0]        remaining,
    output logic                             last
);

    import ths_pkg::*;

    localparam int SW = (TIMERS > 1) ? $clog2(TIMERS) : 1;
    localparam int UW = SW + 1;
    localparam int HW = ID_W + DL_W;
    localparam int PW = IVL_W + 1;

    // Control state.
    logic [DL_W-1:0]   now_reg, now_next;
    logic [UW-1:0]     used_reg, used_next;
    logic [TIMERS-1:0] active_reg, active_next;
    logic [N_W-1:0]    n_reg, n_next;
    logic              pend_reg, pend_next;
    logic              ov_reg, ov_next;

    // Payload registers.
    func_t             func_reg, func_next;
    logic [ID_W-1:0]   tgt_reg, tgt_next;
    logic [IVL_W-1:0]  ivl_reg, ivl_next;
    logic              per_reg, per_next;
    logic [ID_W-1:0]   cur_id_reg, cur_id_next;
    logic [DL_W-1:0]   cur_dl_reg, cur_dl_next;
    logic [ID_W-1:0]   ch_id_reg, ch_id_next;
    logic [DL_W-1:0]   ch_dl_reg, ch_dl_next;
    logic [SW-1:0]     ic_reg, ic_next;
    logic [UW-1:0]     l_reg, l_next;
    logic [2:0]        st_reg, st_next;
    logic              ne_reg, ne_next;
    logic [IVL_W-1:0]  rem_reg, rem_next;
    logic [ID_W-1:0]   pid_reg, pid_next;
    logic [1:0]        okind_reg, okind_next;
    logic [ID_W-1:0]   otim_reg, otim_next;
    logic [2:0]        ost_reg, ost_next;
    logic              one_reg, one_next;
    logic [IVL_W-1:0]  orem_reg, orem_next;
    logic              olast_reg, olast_next;

    // RAM ports.
    logic              h_we, h_re;
    logic [SW-1:0]     h_waddr, h_raddr;
    logic [HW-1:0]     h_wdata, h_q;
    logic              s_we, s_re;
    logic [SW-1:0]     s_waddr;
    logic [SW-1:0]     s_wdata, s_q;
    logic              d_we, d_re;
    logic [DL_W-1:0]   d_q;
    logic              p_we, p_re;
    logic [PW-1:0]     p_q;

    logic [ID_W-1:0]   hq_id;
    logic [DL_W-1:0]   hq_dl;
    logic [SW-1:0]     tgt_idx;
    logic [SW-1:0]     parent;
    logic [UW-1:0]     l_val;
    logic [IVL_W-1:0]  arm_period;
    logic [DL_W-1:0]   arm_dl;
    logic [DL_W-1:0]   q_diff;
    logic [IVL_W-1:0]  rem_calc;
    logic [2:0]        dec_status;
    logic              bad_id, is_act, out_free;

    assign hq_id   = h_q[HW-1:DL_W];
    assign hq_dl   = h_q[DL_W-1:0];
    assign tgt_idx = SW'(tgt_reg);
    assign parent  = SW'((ic_reg - SW'(1)) >> 1);
    assign l_val   = {ic_reg, 1'b1};
    assign bad_id  = (32'(tgt_reg) >= 32'(TIMERS));
    assign is_act  = active_reg[tgt_idx];
    assign out_free = !ov_reg || out_ready;

    // Deadline of an armed timer.
    assign arm_period = (func_reg == FN_START) ? ivl_reg : p_q[IVL_W-1:0];
    assign arm_dl     = now_reg + DL_W'(arm_period);

    // Query remaining time, saturated to 32 bits.
    assign q_diff = d_q - now_reg;
    always_comb
    begin
        rem_calc = '0;
        if (is_act && (d_q > now_reg))
        begin
            rem_calc = (q_diff[DL_W-1:IVL_W] != '0) ? '1 : q_diff[IVL_W-1:0];
        end
    end

    // Reply status of a start, stop or query.
    always_comb
    begin
        dec_status = ST_OK;
        if (bad_id)
        begin
            dec_status = ST_NOT_ACTIVE;
        end
        else
        begin
            case (func_reg)
                FN_START:
                begin
                    if (used_reg >= UW'(TIMERS))
                    begin
                        dec_status = ST_FULL;
                    end
                    else if (ivl_reg == '0)
                    begin
                        dec_status = ST_BAD_IVL;
                    end
                    else if (is_act)
                    begin
                        dec_status = ST_ALREADY;
                    end
                end
                FN_STOP:
                begin
                    dec_status = is_act ? ST_OK : ST_NOT_ACTIVE;
                end
                default:
                begin
                    dec_status = ST_OK;
                end
            endcase
        end
    end

    // Status flags for the controller.
    always_comb
    begin
        st.fn         = func_reg;
        st.bad_id     = bad_id;
        st.reject     = (dec_status != ST_OK);
        st.rise_root  = (ic_reg == '0);
        st.rise_stop  = (cur_dl_reg >= hq_dl);
        st.sink_leaf  = (l_val >= used_reg);
        st.has_right  = (({1'b0, l_reg} + (UW+1)'(1)) < {1'b0, used_reg});
        st.sink_stop  = (ch_dl_reg >= cur_dl_reg);
        st.mv_none    = (UW'(s_q) >= (used_reg - UW'(1)));
        st.heap_empty = (used_reg == '0);
        st.n_full     = (n_reg == N_W'(MAX_OUT));
        st.top_due    = (hq_dl <= now_reg);
        st.pend       = pend_reg;
        st.periodic   = p_q[IVL_W];
        st.out_free   = out_free;
    end

    // RAM port control.
    always_comb
    begin
        h_we    = 1'b0;
        h_waddr = ic_reg;
        h_wdata = {cur_id_reg, cur_dl_reg};
        h_re    = 1'b0;
        h_raddr = '0;
        s_we    = 1'b0;
        s_waddr = SW'(cur_id_reg);
        s_wdata = ic_reg;
        s_re    = 1'b0;
        d_we    = 1'b0;
        d_re    = 1'b0;
        p_we    = 1'b0;
        p_re    = 1'b0;
        case (cmd.code)
            CMD_DECODE:
            begin
                d_re = 1'b1;
            end
            CMD_ARM:
            begin
                d_we = 1'b1;
                p_we = (func_reg == FN_START);
            end
            CMD_RISE_RD:
            begin
                h_re    = 1'b1;
                h_raddr = parent;
            end
            CMD_RISE_MOVE:
            begin
                h_we    = 1'b1;
                h_wdata = h_q;
                s_we    = 1'b1;
                s_waddr = SW'(hq_id);
            end
            CMD_SINK_RD:
            begin
                h_re    = 1'b1;
                h_raddr = SW'(l_val);
            end
            CMD_SINK_LATL:
            begin
                h_re    = 1'b1;
                h_raddr = SW'(l_reg + UW'(1));
            end
            CMD_SINK_MOVE:
            begin
                h_we    = 1'b1;
                h_wdata = {ch_id_reg, ch_dl_reg};
                s_we    = 1'b1;
                s_waddr = SW'(ch_id_reg);
            end
            CMD_PLACE:
            begin
                h_we = 1'b1;
                s_we = 1'b1;
            end
            CMD_DIS_RD:
            begin
                s_re = 1'b1;
                p_re = 1'b1;
            end
            CMD_DIS_MV:
            begin
                h_re    = 1'b1;
                h_raddr = SW'(used_reg - UW'(1));
            end
            CMD_TOP_RD:
            begin
                h_re = 1'b1;
            end
            default:
            begin
                h_re = 1'b0;
            end
        endcase
    end

    // Register next values.
    always_comb
    begin
        now_next    = now_reg;
        used_next   = used_reg;
        active_next = active_reg;
        n_next      = n_reg;
        pend_next   = pend_reg;
        ov_next     = ov_reg;
        func_next   = func_reg;
        tgt_next    = tgt_reg;
        ivl_next    = ivl_reg;
        per_next    = per_reg;
        cur_id_next = cur_id_reg;
        cur_dl_next = cur_dl_reg;
        ch_id_next  = ch_id_reg;
        ch_dl_next  = ch_dl_reg;
        ic_next     = ic_reg;
        l_next      = l_reg;
        st_next     = st_reg;
        ne_next     = ne_reg;
        rem_next    = rem_reg;
        pid_next    = pid_reg;
        okind_next  = okind_reg;
        otim_next   = otim_reg;
        ost_next    = ost_reg;
        one_next    = one_reg;
        orem_next   = orem_reg;
        olast_next  = olast_reg;

        // The output register empties on a transfer.
        if (ov_reg && out_ready)
        begin
            ov_next = 1'b0;
        end

        case (cmd.code)
            CMD_ACCEPT:
            begin
                func_next = func_t'(func);
                tgt_next  = timer_id;
                ivl_next  = interval;
                per_next  = periodic;
            end
            CMD_DECODE:
            begin
                st_next  = dec_status;
                ne_next  = 1'b0;
                rem_next = '0;
            end
            CMD_QRY:
            begin
                rem_next = rem_calc;
            end
            CMD_TICK:
            begin
                now_next  = now_reg + DL_W'(1);
                n_next    = '0;
                pend_next = 1'b0;
            end
            CMD_ARM:
            begin
                cur_id_next          = tgt_reg;
                cur_dl_next          = arm_dl;
                active_next[tgt_idx] = 1'b1;
                ic_next              = SW'(used_reg);
                used_next            = used_reg + UW'(1);
            end
            CMD_ARM_DONE:
            begin
                if (func_reg == FN_TICK)
                begin
                    pend_next = 1'b1;
                    pid_next  = tgt_reg;
                    n_next    = n_reg + N_W'(1);
                end
            end
            CMD_RISE_MOVE:
            begin
                ic_next = parent;
            end
            CMD_SINK_RD:
            begin
                l_next = l_val;
            end
            CMD_SINK_LATL:
            begin
                ch_id_next = hq_id;
                ch_dl_next = hq_dl;
            end
            CMD_SINK_PICK:
            begin
                if (hq_dl < ch_dl_reg)
                begin
                    ch_id_next = hq_id;
                    ch_dl_next = hq_dl;
                    l_next     = l_reg + UW'(1);
                end
            end
            CMD_SINK_MOVE:
            begin
                ic_next = SW'(l_reg);
            end
            CMD_PLACE:
            begin
                if (func_reg == FN_START)
                begin
                    ne_next = (ic_reg == '0);
                end
            end
            CMD_DIS_MV:
            begin
                ic_next   = s_q;
                used_next = used_reg - UW'(1);
            end
            CMD_DIS_LD:
            begin
                cur_id_next = hq_id;
                cur_dl_next = hq_dl;
            end
            CMD_DIS_DONE:
            begin
                active_next[tgt_idx] = 1'b0;
                if ((func_reg == FN_TICK) && !p_q[IVL_W])
                begin
                    pend_next = 1'b1;
                    pid_next  = tgt_reg;
                    n_next    = n_reg + N_W'(1);
                end
            end
            CMD_POP:
            begin
                tgt_next = hq_id;
                if (pend_reg)
                begin
                    ov_next    = 1'b1;
                    okind_next = KIND_EXPIRY;
                    otim_next  = pid_reg;
                    ost_next   = ST_OK;
                    one_next   = 1'b0;
                    orem_next  = '0;
                    olast_next = 1'b0;
                    pend_next  = 1'b0;
                end
            end
            CMD_EMIT_END:
            begin
                ov_next    = 1'b1;
                okind_next = pend_reg ? KIND_EXPIRY : KIND_IDLE;
                otim_next  = pend_reg ? pid_reg : '0;
                ost_next   = ST_OK;
                one_next   = 1'b0;
                orem_next  = '0;
                olast_next = 1'b1;
                pend_next  = 1'b0;
            end
            CMD_REPLY:
            begin
                ov_next    = 1'b1;
                okind_next = KIND_REPLY;
                otim_next  = tgt_reg;
                ost_next   = st_reg;
                one_next   = ne_reg;
                orem_next  = rem_reg;
                olast_next = 1'b1;
            end
            default:
            begin
                ov_next = ov_next;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            now_reg    <= '0;
            used_reg   <= '0;
            active_reg <= '0;
            n_reg      <= '0;
            pend_reg   <= 1'b0;
            ov_reg     <= 1'b0;
        end
        else
        begin
            now_reg    <= now_next;
            used_reg   <= used_next;
            active_reg <= active_next;
            n_reg      <= n_next;
            pend_reg   <= pend_next;
            ov_reg     <= ov_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        func_reg   <= func_next;
        tgt_reg    <= tgt_next;
        ivl_reg    <= ivl_next;
        per_reg    <= per_next;
        cur_id_reg <= cur_id_next;
        cur_dl_reg <= cur_dl_next;
        ch_id_reg  <= ch_id_next;
        ch_dl_reg  <= ch_dl_next;
        ic_reg     <= ic_next;
        l_reg      <= l_next;
        st_reg     <= st_next;
        ne_reg     <= ne_next;
        rem_reg    <= rem_next;
        pid_reg    <= pid_next;
        okind_reg  <= okind_next;
        otim_reg   <= otim_next;
        ost_reg    <= ost_next;
        one_reg    <= one_next;
        orem_reg   <= orem_next;
        olast_reg  <= olast_next;
    end

    // Heap slots: timer id and deadline, indexed by slot.
    ths_ram #(.WIDTH(HW), .DEPTH(TIMERS)) u_heap (
        .clk   (clk),
        .we    (h_we),
        .waddr (h_waddr),
        .wdata (h_wdata),
        .re    (h_re),
        .raddr (h_raddr),
        .rdata (h_q)
    );

    // Heap slot of each timer.
    ths_ram #(.WIDTH(SW), .DEPTH(TIMERS)) u_slot (
        .clk   (clk),
        .we    (s_we),
        .waddr (s_waddr),
        .wdata (s_wdata),
        .re    (s_re),
        .raddr (tgt_idx),
        .rdata (s_q)
    );

    // Deadline of each timer, for queries.
    ths_ram #(.WIDTH(DL_W), .DEPTH(TIMERS)) u_dl (
        .clk   (clk),
        .we    (d_we),
        .waddr (tgt_idx),
        .wdata (arm_dl),
        .re    (d_re),
        .raddr (tgt_idx),
        .rdata (d_q)
    );

    // Periodic flag and period of each timer.
    ths_ram #(.WIDTH(PW), .DEPTH(TIMERS)) u_per (
        .clk   (clk),
        .we    (p_we),
        .waddr (tgt_idx),
        .wdata ({per_reg, ivl_reg}),
        .re    (p_re),
        .raddr (tgt_idx),
        .rdata (p_q)
    );

    assign out_valid    = ov_reg;
    assign kind         = okind_reg;
    assign result_timer = otim_reg;
    assign status       = ost_reg;
    assign new_earliest = one_reg;
    assign remaining    = orem_reg;
    assign last         = olast_reg;

endmodule

`default_nettype wire

### hw/rtl/timer_heap_scheduler.sv
// Top level of the timer heap scheduler: controller plus datapath.
// Uses ths_pkg, ths_ctrl and ths_dpath.
`timescale 1ns / 1ps
`default_nettype none

// Timer manager keeping up to TIMERS active timers in a binary min-heap of
// deadlines held in RAM. One item is processed at a time. A query and a
// rejected request do no heap work. A start rises one heap level per sift
// step. A stop that removes the last heap slot does no sifting; otherwise
// the moved entry rises and then sinks; with 32 timers that is at most five
// levels. A tick pops each expired timer from the heap top and re-arms a
// periodic one; at most 32 pops per tick. Every sift step reads the heap RAM
// through its registered read port. A result waits in the output register
// while the next item is taken.
module timer_heap_scheduler #(
    parameter int TIMERS = 32
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        in_valid,
    output logic                             in_ready,
    input  wire logic [1:0]                  func,
    input  wire logic [ths_pkg::ID_W-1:0]    timer_id,
    input  wire logic [ths_pkg::IVL_W-1:0]   interval,
    input  wire logic                        periodic,
    output logic                             out_valid,
    input  wire logic                        out_ready,
    output logic [1:0]                       kind,
    output logic [ths_pkg::ID_W-1:0]         result_timer,
    output logic [2:0]                       status,
    output logic                             new_earliest,
    output logic [ths_pkg::IVL_W-1:0]        remaining,
    output logic                             last
);

    import ths_pkg::*;

    ctrl_cmd_t  cmd;
    dp_status_t st;

    ths_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .st       (st),
        .cmd      (cmd)
    );

    ths_dpath #(.TIMERS(TIMERS)) u_dpath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .st           (st),
        .func         (func),
        .timer_id     (timer_id),
        .interval     (interval),
        .periodic     (periodic),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .kind         (kind),
        .result_timer (result_timer),
        .status       (status),
        .new_earliest (new_earliest),
        .remaining    (remaining),
        .last         (last)
    );

endmodule

`default_nettype wire

### hw/rtl/ths_checker.sv
// Port-level assertions for the timer heap scheduler and their bind.
// Uses ths_pkg; binds to timer_heap_scheduler.
`timescale 1ns / 1ps
`default_nettype none

module ths_checker (
    input wire logic                      clk,
    input wire logic                      rst_n,
    input wire logic                      out_valid,
    input wire logic                      out_ready,
    input wire logic [1:0]                kind,
    input wire logic [ths_pkg::ID_W-1:0]  result_timer,
    input wire logic [2:0]                status,
    input wire logic [ths_pkg::IVL_W-1:0] remaining,
    input wire logic                      last
);

    import ths_pkg::*;

    // A stalled result keeps its kind and last flag until its transfer.
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(kind) && $stable(last))
        else $error("result changed while stalled");

    // Only defined result kinds appear.
    a_kind: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (kind == KIND_REPLY || kind == KIND_EXPIRY || kind == KIND_IDLE))
        else $error("undefined result kind");

    // An idle tick is a single result with timer zero.
    a_idle: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && kind == KIND_IDLE |-> last && result_timer == '0)
        else $error("bad idle tick result");

    // A reply ends its item.
    a_reply: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && kind == KIND_REPLY |-> last)
        else $error("reply not marked last");

    // Expiry results carry status OK and no remaining time.
    a_exp: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && kind == KIND_EXPIRY |-> status == ST_OK && remaining == '0)
        else $error("bad expiry fields");

endmodule

bind timer_heap_scheduler ths_checker u_ths_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .kind         (kind),
    .result_timer (result_timer),
    .status       (status),
    .remaining    (remaining),
    .last         (last)
);

`default_nettype wire

### bench/timer_heap_scheduler_tb.sv
// Self-checking testbench for the timer heap scheduler.
// A scoreboard class predicts every result from its own heap model and checks each transfer.
// Depends on ths_pkg and the timer_heap_scheduler RTL.
`timescale 1ns / 1ps

module timer_heap_scheduler_tb;
    import ths_pkg::*;

    localparam int NT = 32;
    localparam int CYCLE_LIMIT = 2000000;

    // One result item as seen on the output ports.
    typedef struct packed {
        logic [1:0]  kind;
        logic [4:0]  tmr;
        logic [2:0]  st;
        logic        ne;
        logic [31:0] rem;
        logic        lst;
    } timer_result_t;

    // Predicts results with its own heap copy and checks transfers in order.
    class timer_scoreboard;
        logic [63:0]   now_ticks;
        logic [4:0]    ids [NT];
        int            used;
        logic [63:0]   due_at [NT];
        logic [31:0]   per_len [NT];
        logic          rearm [NT];
        int            slot_of [NT];
        logic          armed [NT];
        timer_result_t pending [$];
        int            errors;

        function new();
            now_ticks = 0;
            used = 0;
            errors = 0;
            for (int i = 0; i < NT; i++)
            begin
                armed[i] = 0;
                ids[i] = 0;
                due_at[i] = 0;
                per_len[i] = 0;
                rearm[i] = 0;
                slot_of[i] = 0;
            end
        endfunction

        function void place(int s, logic [4:0] id);
            ids[s] = id;
            slot_of[id] = s;
        endfunction

        function int rise(int s, logic [4:0] id);
            int p;
            while (s > 0)
            begin
                p = (s - 1) / 2;
                if (due_at[id] >= due_at[ids[p]])
                    break;
                place(s, ids[p]);
                s = p;
            end
            place(s, id);
            return s;
        endfunction

        function void sink(int s, logic [4:0] id);
            int c;
            forever
            begin
                c = 2 * s + 1;
                if (c >= used)
                    break;
                if (c + 1 < used && due_at[ids[c + 1]] < due_at[ids[c]])
                    c++;
                if (due_at[ids[c]] >= due_at[id])
                    break;
                place(s, ids[c]);
                s = c;
            end
            place(s, id);
        endfunction

        function int arm_timer(logic [4:0] id);
            int s;
            due_at[id] = now_ticks + 64'(per_len[id]);
            armed[id] = 1;
            s = rise(used, id);
            used++;
            return s;
        endfunction

        function void disarm_timer(logic [4:0] id);
            int s;
            logic [4:0] mv;
            s = slot_of[id];
            used--;
            if (s < used)
            begin
                mv = ids[used];
                s = rise(s, mv);
                sink(s, mv);
            end
            armed[id] = 0;
        endfunction

        function void push(logic [1:0] k, logic [4:0] t, logic [2:0] s, logic n,
                           logic [31:0] r, logic l);
            timer_result_t x;
            x.kind = k; x.tmr = t; x.st = s; x.ne = n; x.rem = r; x.lst = l;
            pending.push_back(x);
        endfunction

        // Notes an accepted input transfer and queues its expected results.
        function void note_input(logic [1:0] fn, logic [4:0] id, logic [31:0] ivl,
                                 logic per);
            int n;
            logic [4:0] top;
            logic [2:0] st;
            logic ne;
            logic [63:0] left;
            timer_result_t x;
            n = 0;
            ne = 0;
            st = ST_OK;
            left = 0;
            if (fn == FN_TICK)
            begin
                now_ticks++;
                while (used > 0 && n < MAX_OUT && due_at[ids[0]] <= now_ticks)
                begin
                    top = ids[0];
                    disarm_timer(top);
                    if (rearm[top])
                        void'(arm_timer(top));
                    push(KIND_EXPIRY, top, ST_OK, 0, 0, 0);
                    n++;
                end
                if (n == 0)
                    push(KIND_IDLE, 0, ST_OK, 0, 0, 1);
                else
                begin
                    x = pending.pop_back();
                    x.lst = 1;
                    pending.push_back(x);
                end
            end
            else if (fn == FN_START)
            begin
                if (used >= NT)
                    st = ST_FULL;
                else if (ivl == 0)
                    st = ST_BAD_IVL;
                else if (armed[id])
                    st = ST_ALREADY;
                else
                begin
                    per_len[id] = ivl;
                    rearm[id] = per;
                    ne = (arm_timer(id) == 0);
                end
                push(KIND_REPLY, id, st, ne, 0, 1);
            end
            else if (fn == FN_STOP)
            begin
                if (!armed[id])
                    st = ST_NOT_ACTIVE;
                else
                    disarm_timer(id);
                push(KIND_REPLY, id, st, 0, 0, 1);
            end
            else
            begin
                if (armed[id] && due_at[id] > now_ticks)
                begin
                    left = due_at[id] - now_ticks;
                    if (left > 64'hFFFF_FFFF)
                        left = 64'hFFFF_FFFF;
                end
                push(KIND_REPLY, id, ST_OK, 0, left[31:0], 1);
            end
        endfunction

        // Compares one output transfer with the oldest expectation.
        function void check_result(timer_result_t got);
            timer_result_t exp_r;
            if (pending.size() == 0)
            begin
                errors++;
                if (errors <= 10)
                    $display("Unexpected result: %p", got);
                return;
            end
            exp_r = pending.pop_front();
            if (got !== exp_r)
            begin
                errors++;
                if (errors <= 10)
                    $display("Mismatch: expected %p, actual %p", exp_r, got);
            end
        endfunction
    endclass

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_ready;
    logic [1:0]  func;
    logic [4:0]  timer_id;
    logic [31:0] interval;
    logic        periodic;
    logic        out_valid;
    logic        out_ready;
    logic [1:0]  kind;
    logic [4:0]  result_timer;
    logic [2:0]  status;
    logic        new_earliest;
    logic [31:0] remaining;
    logic        last;

    timer_scoreboard sb;
    int  cycles;
    bit  quiet_phase;
    bit  hold_request;
    bit  stim_done;

    timer_heap_scheduler #(.TIMERS(NT)) u_dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready),
        .func(func), .timer_id(timer_id), .interval(interval), .periodic(periodic),
        .out_valid(out_valid), .out_ready(out_ready),
        .kind(kind), .result_timer(result_timer), .status(status),
        .new_earliest(new_earliest), .remaining(remaining), .last(last)
    );

    always #6 clk = ~clk;

    // Sample both channels at the rising edge.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (in_valid && in_ready)
                sb.note_input(func, timer_id, interval, periodic);
            if (out_valid && out_ready)
                sb.check_result({kind, result_timer, status, new_earliest, remaining, last});
        end
    end

    // Cycle limit.
    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("Verification failed");
            $finish;
        end
    end

    // Receiver: random stalls, one long hold-off, none in the quiet phase.
    initial
    begin
        int burst;
        out_ready = 0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (hold_request)
            begin
                out_ready <= 0;
                repeat (400) @(negedge clk);
                hold_request = 0;
                out_ready <= 1;
            end
            else if (!quiet_phase && $urandom_range(0, 5) == 0)
            begin
                burst = $urandom_range(1, 17);
                out_ready <= 0;
                repeat (burst - 1) @(negedge clk);
            end
            else
                out_ready <= 1;
        end
    end

    // Offers one input transfer and holds it until accepted; valid is left
    // high afterwards and the next call or the caller drops it.
    task automatic send_item(logic [1:0] fn, logic [4:0] id, logic [31:0] ivl, logic per);
        if (!quiet_phase && $urandom_range(0, 4) == 0)
        begin
            in_valid <= 0;
            repeat ($urandom_range(1, 17)) @(negedge clk);
        end
        in_valid <= 1;
        func <= fn;
        timer_id <= id;
        interval <= ivl;
        periodic <= per;
        do
            @(posedge clk);
        while (!in_ready);
        @(negedge clk);
    endtask

    // Mostly short intervals so timers expire often; sometimes any value.
    function automatic logic [31:0] pick_interval();
        case ($urandom_range(0, 9))
            0: return 0;
            1: return $urandom();
            2: return 32'hFFFF_FFFF;
            default: return 32'($urandom_range(1, 12));
        endcase
    endfunction

    initial
    begin
        logic [1:0] fn;
        clk = 0;
        rst_n = 0;
        in_valid = 0;
        func = FN_START;
        timer_id = 0;
        interval = 0;
        periodic = 0;
        cycles = 0;
        quiet_phase = 0;
        hold_request = 0;
        stim_done = 0;
        sb = new();
        repeat (2) @(negedge clk);
        rst_n = 1;
        @(negedge clk);

        // Directed items: field extremes, each operation and rejection.
        send_item(FN_TICK, 0, 0, 0);
        send_item(FN_STOP, 5, 0, 0);
        send_item(FN_QUERY, 31, 0, 0);
        send_item(FN_START, 0, 0, 0);
        send_item(FN_START, 31, 32'hFFFF_FFFF, 1);
        send_item(FN_QUERY, 31, 0, 0);
        send_item(FN_START, 31, 5, 0);
        send_item(FN_START, 3, 3, 1);
        send_item(FN_START, 4, 3, 0);
        send_item(FN_START, 7, 1, 0);
        send_item(FN_QUERY, 3, 0, 0);
        send_item(FN_TICK, 0, 0, 0);
        send_item(FN_STOP, 3, 0, 0);
        send_item(FN_STOP, 3, 0, 0);
        send_item(FN_TICK, 0, 0, 0);
        send_item(FN_TICK, 0, 0, 0);
        send_item(FN_TICK, 0, 0, 0);
        send_item(FN_STOP, 31, 0, 0);

        // Fill the table with equal deadlines, hit full, then expire all at once.
        for (int i = 0; i < NT; i++)
            send_item(FN_START, i[4:0], 2, i[0]);
        send_item(FN_START, 9, 4, 0);
        hold_request = 1;
        send_item(FN_TICK, 0, 0, 0);
        send_item(FN_TICK, 0, 0, 0);
        for (int i = 0; i < 8; i++)
            send_item(FN_QUERY, i[4:0], 0, 0);
        for (int i = 0; i < NT; i += 2)
            send_item(FN_STOP, i[4:0], 0, 0);

        // Random traffic, weighted toward starts and ticks.
        for (int n = 0; n < 150; n++)
        begin
            if (n == 115)
                quiet_phase = 1;
            case ($urandom_range(0, 9))
                0, 1, 2, 3: fn = FN_START;
                4, 5: fn = FN_STOP;
                6, 7, 8: fn = FN_TICK;
                default: fn = FN_QUERY;
            endcase
            send_item(fn, 5'($urandom_range(0, 31)), pick_interval(),
                      1'($urandom_range(0, 1)));
        end
        in_valid <= 0;

        // Drain, then allow the block to settle.
        while (sb.pending.size() != 0 || hold_request)
            @(negedge clk);
        repeat (200) @(negedge clk);
        if (sb.errors == 0 && sb.pending.size() == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end
endmodule
